[hw/rtl/vrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

    // payload of one transaction in each direction
    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_vrp_in;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] depth;
        logic               w_zero;
    } t_vrp_out;

    // configuration register map
    localparam int VRP_NUM_REGS = 8;
    localparam int VRP_IDX_W    = 3;

    typedef enum logic [VRP_IDX_W-1:0] {
        REG_COS_Z        = 3'd0,
        REG_SIN_Z        = 3'd1,
        REG_COS_X        = 3'd2,
        REG_SIN_X        = 3'd3,
        REG_PROJ_X_SCALE = 3'd4,
        REG_PROJ_Y_SCALE = 3'd5,
        REG_DEPTH_SCALE  = 3'd6,
        REG_DEPTH_OFFSET = 3'd7
    } t_vrp_reg;

    function automatic logic [15:0] vrp_cfg_reset(input t_vrp_reg idx);
        logic [15:0] v;
        case (idx)
            REG_COS_Z:        v = 16'd16384;
            REG_SIN_Z:        v = 16'd0;
            REG_COS_X:        v = 16'd16384;
            REG_SIN_X:        v = 16'd0;
            REG_PROJ_X_SCALE: v = 16'd3840;
            REG_PROJ_Y_SCALE: v = 16'd4096;
            REG_DEPTH_SCALE:  v = 16'd4096;
            REG_DEPTH_OFFSET: v = 16'hfe66;
            default:          v = 16'd0;
        endcase
        return v;
    endfunction

    // screen size defaults, factor width covers the largest allowed size
    localparam int VRP_SCREEN_WIDTH  = 256;
    localparam int VRP_SCREEN_HEIGHT = 240;
    localparam int VRP_SCR_BW        = 14;

    // divider geometry: numerator magnitude, divisor magnitude, remainder
    localparam int VRP_ND = 40;
    localparam int VRP_DW = 23;
    localparam int VRP_RW = VRP_DW + 1;
    localparam int VRP_AW = VRP_RW + VRP_ND;
    localparam int VRP_ZW = 29;

    // travels next to the quotients through the divider
    typedef struct packed {
        logic                     w_zero;
        logic [2:0]               neg;
        logic signed [VRP_ZW-1:0] zx;
        logic signed [VRP_ZW-1:0] zy;
        logic signed [VRP_ZW-1:0] zz;
    } t_vrp_side;

    // one restoring step: shift in a numerator bit, subtract if it fits
    function automatic logic [VRP_AW-1:0] vrp_div_step(input logic [VRP_AW-1:0] acc,
                                                       input logic [VRP_DW-1:0] d);
        logic [VRP_AW-1:0] sh;
        logic [VRP_RW-1:0] top;
        sh  = acc << 1;
        top = sh[VRP_AW-1:VRP_ND];
        if (top >= {1'b0, d}) begin
            sh[VRP_AW-1:VRP_ND] = top - {1'b0, d};
            sh[0]               = 1'b1;
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/vrp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module vrp_div
    import vrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [VRP_ND-1:0] i_mag [3],
    input  wire logic [VRP_DW-1:0] i_div,
    input  wire t_vrp_side         i_side,
    output logic                   o_vld,
    output logic [VRP_ND-1:0]      o_quo [3],
    output t_vrp_side              o_side
);

    logic [VRP_AW-1:0] r_acc  [VRP_ND][3];
    logic [VRP_DW-1:0] r_d    [VRP_ND];
    t_vrp_side         r_side [VRP_ND];
    logic [VRP_ND-1:0] r_vld;

    genvar l;

    // valid bits shift along with the quotient stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VRP_ND-2:0], i_vld};
        end
    end

    // one quotient bit per stage, first stage starts from a zero remainder
    always_ff @(posedge i_clk) begin
        r_d[0]    <= i_div;
        r_side[0] <= i_side;
        for (int k = 0; k < 3; k++) begin
            r_acc[0][k] <= vrp_div_step({{VRP_RW{1'b0}}, i_mag[k]}, i_div);
        end
        for (int s = 1; s < VRP_ND; s++) begin
            r_d[s]    <= r_d[s-1];
            r_side[s] <= r_side[s-1];
            for (int k = 0; k < 3; k++) begin
                r_acc[s][k] <= vrp_div_step(r_acc[s-1][k], r_d[s-1]);
            end
        end
    end

    assign o_vld  = r_vld[VRP_ND-1];
    assign o_side = r_side[VRP_ND-1];
    for (l = 0; l < 3; l++) begin : g_out
        assign o_quo[l] = r_acc[VRP_ND-1][l][VRP_ND-1:0];
    end

    // remainder always ends below a nonzero divisor
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && r_d[VRP_ND-1] != '0) |->
        (r_acc[VRP_ND-1][0][VRP_AW-1:VRP_ND] < {1'b0, r_d[VRP_ND-1]}))
        else $error("x remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && r_d[VRP_ND-1] != '0) |->
        (r_acc[VRP_ND-1][1][VRP_AW-1:VRP_ND] < {1'b0, r_d[VRP_ND-1]}))
        else $error("y remainder not below divisor");
    a_rem_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && r_d[VRP_ND-1] != '0) |->
        (r_acc[VRP_ND-1][2][VRP_AW-1:VRP_ND] < {1'b0, r_d[VRP_ND-1]}))
        else $error("z remainder not below divisor");
    // zero flag stays tied to the divisor it was raised for
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_side.w_zero == (r_d[VRP_ND-1] == '0)))
        else $error("zero flag lost track of divisor");
    // valid leaves the last stage only after the one before held it
    a_vld_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(r_vld[VRP_ND-2]))
        else $error("valid appeared without predecessor");

endmodule

`default_nettype wire

[hw/rtl/vertex_rotate_project_viewport_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// vertex transform core: a signed q4.12 vertex is rotated about z, then about x
// by the programmed cosine/sine pairs, moved by +3.0 in z and projected by w
// (the moved z); the viewport map then gives integer pixel x and y, saturated,
// plus the projected depth. when w is zero the divide is skipped, the
// numerators are only rounded and w_zero is set. a transaction is taken on
// every edge where i_start is high and o_busy low; o_busy is high only during
// reset, so one vertex enters per clock. each result is shown for exactly one
// cycle with o_valid high; the receiver cannot stall, so the pipeline never
// holds. the pipeline has 6 transform stages, 40 stages of the
// shared-divisor restoring divider (one quotient bit each) and 4 viewport
// stages. write configuration only while no vertex is in flight.

module vertex_rotate_project_viewport_core
    import vrp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = VRP_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = VRP_SCREEN_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire t_vrp_in              i_vertex,
    input  wire logic                 i_cfg_we,
    input  wire logic [VRP_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]          i_cfg_wdata,
    output logic                      o_valid,
    output t_vrp_out                  o_result
);

    // pixel scale factors, positive and small enough for the factor width
    localparam logic signed [VRP_SCR_BW-1:0] ScrW = VRP_SCR_BW'(SCREEN_WIDTH);
    localparam logic signed [VRP_SCR_BW-1:0] ScrH = VRP_SCR_BW'(SCREEN_HEIGHT);

    // configuration registers
    logic [15:0] r_cfg [VRP_NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VRP_NUM_REGS; k++) begin
                r_cfg[k] <= vrp_cfg_reset(t_vrp_reg'(k));
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    logic signed [15:0] c_cz, c_sz, c_cx, c_sx, c_pxs, c_pys, c_ds, c_doff;
    assign c_cz   = r_cfg[REG_COS_Z];
    assign c_sz   = r_cfg[REG_SIN_Z];
    assign c_cx   = r_cfg[REG_COS_X];
    assign c_sx   = r_cfg[REG_SIN_X];
    assign c_pxs  = r_cfg[REG_PROJ_X_SCALE];
    assign c_pys  = r_cfg[REG_PROJ_Y_SCALE];
    assign c_ds   = r_cfg[REG_DEPTH_SCALE];
    assign c_doff = r_cfg[REG_DEPTH_OFFSET];

    // always ready outside reset
    assign o_busy = ~i_rst_n;

    logic w_accept;
    assign w_accept = i_start & ~o_busy;

    // valid bits for the stages around the divider
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic r7_vld, r8_vld, r9_vld, r10_vld;
    logic w_div_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else begin
            r1_vld  <= w_accept;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= w_div_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    // stage 1: z rotation products
    logic signed [31:0] n1_xc, n1_ys, n1_xs, n1_yc;
    logic signed [31:0] r1_xc, r1_ys, r1_xs, r1_yc;
    logic signed [15:0] r1_z;

    always_comb begin
        n1_xc = i_vertex.vertex_x * c_cz;
        n1_ys = i_vertex.vertex_y * c_sz;
        n1_xs = i_vertex.vertex_x * c_sz;
        n1_yc = i_vertex.vertex_y * c_cz;
    end

    always_ff @(posedge i_clk) begin
        r1_xc <= n1_xc;
        r1_ys <= n1_ys;
        r1_xs <= n1_xs;
        r1_yc <= n1_yc;
        r1_z  <= i_vertex.vertex_z;
    end

    // stage 2: z rotation sums, round half up to q.12
    logic signed [33:0] n2_xa, n2_ya;
    logic signed [19:0] r2_x1, r2_y1;
    logic signed [15:0] r2_z;

    always_comb begin
        n2_xa = 34'(r1_xc) - 34'(r1_ys) + 34'sd8192;
        n2_ya = 34'(r1_xs) + 34'(r1_yc) + 34'sd8192;
    end

    always_ff @(posedge i_clk) begin
        r2_x1 <= 20'(n2_xa >>> 14);
        r2_y1 <= 20'(n2_ya >>> 14);
        r2_z  <= r1_z;
    end

    // stage 3: x rotation products
    logic signed [35:0] n3_yc, n3_ys;
    logic signed [31:0] n3_zs, n3_zc;
    logic signed [35:0] r3_yc, r3_ys;
    logic signed [31:0] r3_zs, r3_zc;
    logic signed [19:0] r3_x1;

    always_comb begin
        n3_yc = r2_y1 * c_cx;
        n3_ys = r2_y1 * c_sx;
        n3_zs = r2_z * c_sx;
        n3_zc = r2_z * c_cx;
    end

    always_ff @(posedge i_clk) begin
        r3_yc <= n3_yc;
        r3_ys <= n3_ys;
        r3_zs <= n3_zs;
        r3_zc <= n3_zc;
        r3_x1 <= r2_x1;
    end

    // stage 4: x rotation sums and the +3.0 translation giving w
    logic signed [37:0] n4_ya, n4_za;
    logic signed [21:0] r4_y2;
    logic signed [22:0] r4_w;
    logic signed [19:0] r4_x1;

    always_comb begin
        n4_ya = 38'(r3_yc) - 38'(r3_zs) + 38'sd8192;
        n4_za = 38'(r3_ys) + 38'(r3_zc) + 38'sd8192;
    end

    always_ff @(posedge i_clk) begin
        r4_y2 <= 22'(n4_ya >>> 14);
        r4_w  <= 23'(n4_za >>> 14) + 23'sd12288;
        r4_x1 <= r3_x1;
    end

    // stage 5: projection numerator products (q.24)
    logic signed [35:0] n5_nx;
    logic signed [37:0] n5_ny;
    logic signed [38:0] n5_nw;
    logic signed [35:0] r5_nx;
    logic signed [37:0] r5_ny;
    logic signed [38:0] r5_nw;
    logic signed [22:0] r5_w;

    always_comb begin
        n5_nx = r4_x1 * c_pxs;
        n5_ny = r4_y2 * c_pys;
        n5_nw = r4_w * c_ds;
    end

    always_ff @(posedge i_clk) begin
        r5_nx <= n5_nx;
        r5_ny <= n5_ny;
        r5_nw <= n5_nw;
        r5_w  <= r4_w;
    end

    // stage 6: depth numerator gets the offset
    logic signed [VRP_ND-1:0] r6_n [3];
    logic signed [22:0]       r6_w;

    always_ff @(posedge i_clk) begin
        r6_n[0] <= VRP_ND'(r5_nx);
        r6_n[1] <= VRP_ND'(r5_ny);
        r6_n[2] <= VRP_ND'(r5_nw) + (VRP_ND'(c_doff) <<< 12);
        r6_w    <= r5_w;
    end

    // sign/magnitude split feeding the divider, plus the zero-w rounding path
    logic signed [VRP_ND:0]   w_next [3];
    logic signed [VRP_ND:0]   w_rnd  [3];
    logic [VRP_ND-1:0]        w_mag  [3];
    logic signed [VRP_ZW-1:0] w_zr   [3];
    logic [2:0]               w_nneg;
    logic signed [23:0]       w_wx;
    logic                     w_wneg;
    logic [VRP_DW-1:0]        w_dmag;
    t_vrp_side                w_side_in;

    always_comb begin
        w_wx   = 24'(r6_w);
        w_wneg = r6_w[22];
        w_dmag = VRP_DW'(w_wneg ? -w_wx : w_wx);
        for (int k = 0; k < 3; k++) begin
            w_next[k] = (VRP_ND+1)'(r6_n[k]);
            w_nneg[k] = r6_n[k][VRP_ND-1];
            w_mag[k]  = VRP_ND'(w_nneg[k] ? -w_next[k] : w_next[k]);
            w_rnd[k]  = w_next[k] + (VRP_ND+1)'(2048);
            w_zr[k]   = VRP_ZW'(w_rnd[k] >>> 12);
        end
        w_side_in.w_zero = (r6_w == '0);
        w_side_in.neg    = w_nneg ^ {3{w_wneg}};
        w_side_in.zx     = w_zr[0];
        w_side_in.zy     = w_zr[1];
        w_side_in.zz     = w_zr[2];
    end

    logic [VRP_ND-1:0] w_quo [3];
    t_vrp_side         w_side_out;

    vrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r6_vld),
        .i_mag   (w_mag),
        .i_div   (w_dmag),
        .i_side  (w_side_in),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_side_out)
    );

    // stage 7: signed projected values, or the rounded ones when w was zero
    logic signed [VRP_ND:0] n7_p [3];
    logic signed [VRP_ND:0] r7_p [3];
    logic signed [VRP_ZW-1:0] w_zsel [3];
    logic signed [VRP_ND:0] w_q [3];
    logic                   r7_wz;

    always_comb begin
        w_zsel[0] = w_side_out.zx;
        w_zsel[1] = w_side_out.zy;
        w_zsel[2] = w_side_out.zz;
        for (int k = 0; k < 3; k++) begin
            w_q[k] = {1'b0, w_quo[k]};
            if (w_side_out.w_zero) begin
                n7_p[k] = (VRP_ND+1)'(w_zsel[k]);
            end else if (w_side_out.neg[k]) begin
                n7_p[k] = -w_q[k];
            end else begin
                n7_p[k] = w_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r7_p[k] <= n7_p[k];
        end
        r7_wz <= w_side_out.w_zero;
    end

    // stage 8: (p + 1.0), clamped where the pixel result saturates anyway; depth saturated to 16 bits
    localparam logic signed [VRP_ND+1:0] TMax = (VRP_ND+2)'((1 << 28) - 1);
    localparam logic signed [VRP_ND+1:0] TMin = -(VRP_ND+2)'(1 << 28);

    logic signed [VRP_ND+1:0] n8_tx, n8_ty;
    logic signed [28:0]       r8_tx, r8_ty;
    logic signed [15:0]       n8_depth, r8_depth;
    logic                     r8_wz;

    always_comb begin
        n8_tx = (VRP_ND+2)'(r7_p[0]) + (VRP_ND+2)'(4096);
        n8_ty = (VRP_ND+2)'(r7_p[1]) + (VRP_ND+2)'(4096);
        if (n8_tx > TMax) begin
            n8_tx = TMax;
        end else if (n8_tx < TMin) begin
            n8_tx = TMin;
        end
        if (n8_ty > TMax) begin
            n8_ty = TMax;
        end else if (n8_ty < TMin) begin
            n8_ty = TMin;
        end
        if (r7_p[2] > (VRP_ND+1)'(32767)) begin
            n8_depth = 16'sh7fff;
        end else if (r7_p[2] < -(VRP_ND+1)'(32768)) begin
            n8_depth = -16'sh8000;
        end else begin
            n8_depth = 16'(r7_p[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r8_tx    <= 29'(n8_tx);
        r8_ty    <= 29'(n8_ty);
        r8_depth <= n8_depth;
        r8_wz    <= r7_wz;
    end

    // stage 9: scale by screen size
    logic signed [42:0] n9_px, n9_py, r9_px, r9_py;
    logic signed [15:0] r9_depth;
    logic               r9_wz;

    always_comb begin
        n9_px = r8_tx * ScrW;
        n9_py = r8_ty * ScrH;
    end

    always_ff @(posedge i_clk) begin
        r9_px    <= n9_px;
        r9_py    <= n9_py;
        r9_depth <= r8_depth;
        r9_wz    <= r8_wz;
    end

    // stage 10: halve into pixels (floor) and saturate
    logic signed [42:0] w_sx, w_sy;
    t_vrp_out           n10_res, r10_res;

    always_comb begin
        w_sx = r9_px >>> 13;
        w_sy = r9_py >>> 13;
        if (w_sx > 43'sd32767) begin
            n10_res.screen_x = 16'sh7fff;
        end else if (w_sx < -43'sd32768) begin
            n10_res.screen_x = -16'sh8000;
        end else begin
            n10_res.screen_x = 16'(w_sx);
        end
        if (w_sy > 43'sd32767) begin
            n10_res.screen_y = 16'sh7fff;
        end else if (w_sy < -43'sd32768) begin
            n10_res.screen_y = -16'sh8000;
        end else begin
            n10_res.screen_y = 16'(w_sy);
        end
        n10_res.depth  = r9_depth;
        n10_res.w_zero = r9_wz;
    end

    always_ff @(posedge i_clk) begin
        r10_res <= n10_res;
    end

    assign o_valid  = r10_vld;
    assign o_result = r10_res;

endmodule

`default_nettype wire
